// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disabling it.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("completion decoder check failed");

// Same-cycle implication built on the clocked form.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

`endif

// File: src/cmd_pkg.sv
// Types and constants of the completion message decoder.
package cmd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] ALL_ONES_WORD = '1;

    // Record kinds.
    typedef enum logic [1:0] {
        KIND_COMPLETE   = 2'd0,
        KIND_DONE       = 2'd1,
        KIND_PARITY     = 2'd2,
        KIND_ZERO_FRAME = 2'd3
    } kind_t;

    // Position in the message sequence.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_SECOND  = 2'd1,
        PH_MASK_LO = 2'd2,
        PH_MASK_HI = 2'd3
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
        logic [WORD_W-1:0] word3;
    } msg_t;

    // Input register contents.
    typedef struct packed {
        logic valid;
        msg_t msg;
    } stage_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] handle;
        logic [7:0]  module_id;
        logic [15:0] pkt_count;
        logic [63:0] frame_or_bytes;
        logic [31:0] debug_word;
        logic [31:0] time_stamp;
        logic [63:0] bunch_id;
        logic [63:0] mask_part0;
        logic [63:0] mask_part1;
        logic [63:0] mask_part2;
        logic [63:0] mask_part3;
    } rec_t;

    // Decoder result for the item in the input register.
    typedef struct packed {
        logic has_result;
        rec_t rec;
    } result_t;

endpackage

// File: src/cmd_if.sv
// Handshake interfaces for mailbox messages and completion records.
interface cmd_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;

    modport source (output valid, output word0, output word1, output word2,
                    output word3, input ready);
    modport sink   (input valid, input word0, input word1, input word2,
                    input word3, output ready);
endinterface

interface cmd_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] handle;
    logic [7:0]  module_id;
    logic [15:0] pkt_count;
    logic [63:0] frame_or_bytes;
    logic [31:0] debug_word;
    logic [31:0] time_stamp;
    logic [63:0] bunch_id;
    logic [63:0] mask_part0;
    logic [63:0] mask_part1;
    logic [63:0] mask_part2;
    logic [63:0] mask_part3;

    modport source (output valid, output kind, output handle, output module_id,
                    output pkt_count, output frame_or_bytes, output debug_word,
                    output time_stamp, output bunch_id, output mask_part0,
                    output mask_part1, output mask_part2, output mask_part3,
                    input ready);
    modport sink   (input valid, input kind, input handle, input module_id,
                    input pkt_count, input frame_or_bytes, input debug_word,
                    input time_stamp, input bunch_id, input mask_part0,
                    input mask_part1, input mask_part2, input mask_part3,
                    output ready);
endinterface

// File: src/cmd_in_stage.sv
// Input register that captures one mailbox message.
module cmd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    cmd_msg_if.sink            msg,
    input  logic               advance,
    output cmd_pkg::stage_t    stage
);

    logic              valid_reg;
    logic              valid_next;
    cmd_pkg::msg_t     msg_reg;

    // The register takes a new item when empty or when its item moves on.
    assign msg.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (msg.ready)
        begin
            valid_next = msg.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            msg_reg <= '{word0: msg.word0, word1: msg.word1,
                         word2: msg.word2, word3: msg.word3};
        end
    end

    assign stage.valid = valid_reg;
    assign stage.msg   = msg_reg;

endmodule

// File: src/cmd_decode.sv
// Message sequencer: holds the header and mask words and forms records.
module cmd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_pkg::stage_t    stage,
    input  logic               advance,
    output cmd_pkg::result_t   result
);

    cmd_pkg::phase_t phase_reg;
    cmd_pkg::phase_t phase_next;

    logic [31:0] held_handle_reg;
    logic [7:0]  held_module_reg;
    logic [15:0] held_count_reg;
    logic        held_all_ok_reg;
    logic [63:0] held_frame_reg;
    logic [31:0] held_debug_reg;
    logic [31:0] held_stamp_reg;
    logic [63:0] held_bunch_reg;
    logic [63:0] held_mask_a_reg;
    logic [63:0] held_mask_b_reg;

    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic        is_done;
    logic        bad_parity;
    logic        frame_zero;
    logic        fire;

    assign w0 = stage.msg.word0;
    assign w1 = stage.msg.word1;
    assign w2 = stage.msg.word2;
    assign w3 = stage.msg.word3;

    assign is_done    = (w0 == cmd_pkg::ALL_ONES_WORD);
    assign bad_parity = ^(w0 ^ w1 ^ w2 ^ w3);
    assign frame_zero = (held_frame_reg == 64'd0);
    assign fire       = stage.valid && advance;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            cmd_pkg::PH_HEADER:
            begin
                if (!is_done && !bad_parity)
                begin
                    phase_next = cmd_pkg::PH_SECOND;
                end
            end
            cmd_pkg::PH_SECOND:
            begin
                if (!frame_zero && !held_all_ok_reg)
                begin
                    phase_next = cmd_pkg::PH_MASK_LO;
                end
                else
                begin
                    phase_next = cmd_pkg::PH_HEADER;
                end
            end
            cmd_pkg::PH_MASK_LO:
            begin
                phase_next = cmd_pkg::PH_MASK_HI;
            end
            cmd_pkg::PH_MASK_HI:
            begin
                phase_next = cmd_pkg::PH_HEADER;
            end
            default:
            begin
                phase_next = cmd_pkg::PH_HEADER;
            end
        endcase
    end

    // Record built from the current phase and the item in the input register.
    always_comb
    begin
        result.has_result = 1'b0;
        result.rec        = '0;
        result.rec.kind   = cmd_pkg::KIND_COMPLETE;
        unique case (phase_reg)
            cmd_pkg::PH_HEADER:
            begin
                if (is_done)
                begin
                    result.has_result          = 1'b1;
                    result.rec.kind            = cmd_pkg::KIND_DONE;
                    result.rec.frame_or_bytes  = {20'd0, w1, 12'd0};
                end
                else if (bad_parity)
                begin
                    result.has_result          = 1'b1;
                    result.rec.kind            = cmd_pkg::KIND_PARITY;
                    result.rec.handle          = w0;
                    result.rec.module_id       = w1[7:0];
                    result.rec.pkt_count       = w1[31:16];
                end
            end
            cmd_pkg::PH_SECOND:
            begin
                result.rec.handle       = held_handle_reg;
                result.rec.module_id    = held_module_reg;
                result.rec.pkt_count    = held_count_reg;
                result.rec.debug_word   = w0;
                result.rec.time_stamp   = w1;
                result.rec.bunch_id     = {w2, w3};
                if (frame_zero)
                begin
                    result.has_result = 1'b1;
                    result.rec.kind   = cmd_pkg::KIND_ZERO_FRAME;
                end
                else if (held_all_ok_reg)
                begin
                    result.has_result         = 1'b1;
                    result.rec.frame_or_bytes = held_frame_reg - 64'd1;
                    result.rec.mask_part0     = '1;
                    result.rec.mask_part1     = '1;
                    result.rec.mask_part2     = '1;
                    result.rec.mask_part3     = '1;
                end
            end
            cmd_pkg::PH_MASK_LO:
            begin
                result.has_result = 1'b0;
            end
            cmd_pkg::PH_MASK_HI:
            begin
                result.has_result         = 1'b1;
                result.rec.handle         = held_handle_reg;
                result.rec.module_id      = held_module_reg;
                result.rec.pkt_count      = held_count_reg;
                result.rec.frame_or_bytes = held_frame_reg - 64'd1;
                result.rec.debug_word     = held_debug_reg;
                result.rec.time_stamp     = held_stamp_reg;
                result.rec.bunch_id       = held_bunch_reg;
                result.rec.mask_part0     = held_mask_a_reg;
                result.rec.mask_part1     = held_mask_b_reg;
                result.rec.mask_part2     = {w2, w3};
                result.rec.mask_part3     = {w0, w1};
            end
            default:
            begin
                result.has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cmd_pkg::PH_HEADER;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
        end
    end

    // Held fields are always written before they are read, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            case (phase_reg)
                cmd_pkg::PH_HEADER:
                begin
                    held_handle_reg <= w0;
                    held_module_reg <= w1[7:0];
                    held_count_reg  <= w1[31:16];
                    held_all_ok_reg <= w1[8];
                    held_frame_reg  <= {w2, w3};
                end
                cmd_pkg::PH_SECOND:
                begin
                    held_debug_reg <= w0;
                    held_stamp_reg <= w1;
                    held_bunch_reg <= {w2, w3};
                end
                cmd_pkg::PH_MASK_LO:
                begin
                    held_mask_a_reg <= {w2, w3};
                    held_mask_b_reg <= {w0, w1};
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: src/cmd_out_stage.sv
// Result register that presents one completion record downstream.
module cmd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cmd_pkg::rec_t      rec_in,
    output logic               free,
    cmd_rec_if.source          rec
);

    logic          valid_reg;
    logic          valid_next;
    cmd_pkg::rec_t data_reg;

    // The register can take a record when empty or being emptied this cycle.
    assign free = !valid_reg || rec.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rec.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rec_in;
        end
    end

    assign rec.valid          = valid_reg;
    assign rec.kind           = data_reg.kind;
    assign rec.handle         = data_reg.handle;
    assign rec.module_id      = data_reg.module_id;
    assign rec.pkt_count      = data_reg.pkt_count;
    assign rec.frame_or_bytes = data_reg.frame_or_bytes;
    assign rec.debug_word     = data_reg.debug_word;
    assign rec.time_stamp     = data_reg.time_stamp;
    assign rec.bunch_id       = data_reg.bunch_id;
    assign rec.mask_part0     = data_reg.mask_part0;
    assign rec.mask_part1     = data_reg.mask_part1;
    assign rec.mask_part2     = data_reg.mask_part2;
    assign rec.mask_part3     = data_reg.mask_part3;

endmodule

// File: src/completion_message_decoder.sv
// Top level of the completion message decoder.
//
//  channel  direction  payload                                    handshake
//  msg      in         word0..word3, 32 bits each                 valid/ready
//  rec      out        kind, handle, module_id, pkt_count,        valid/ready
//                      frame_or_bytes, debug/time/bunch, masks
//
// One message per cycle is sustained while the result register can take each record;
// a record passes through the input register and then the result register to the port.
// Messages that finish no record move on even while a record waits.
// Reset clears the phase to awaiting a header and empties both registers.
// A stalled record holds the decoder only when the next item also yields one.
module completion_message_decoder (
    input  logic      clk,
    input  logic      rst_n,
    cmd_msg_if.sink   msg,
    cmd_rec_if.source rec
);

    cmd_pkg::stage_t  stage;
    cmd_pkg::result_t result;
    logic             out_free;
    logic             advance;

    // The held item moves on unless its record finds the result register full.
    assign advance = stage.valid && (!result.has_result || out_free);

    cmd_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg),
        .advance (advance),
        .stage   (stage)
    );

    cmd_decode u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

    cmd_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && result.has_result),
        .rec_in (result.rec),
        .free   (out_free),
        .rec    (rec)
    );

endmodule

// File: src/cmd_checker.sv
// Port-level checks on the completion message decoder and their binding.
`include "assert_macros.svh"

module cmd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rec_valid,
    input logic        rec_ready,
    input logic [1:0]  rec_kind,
    input logic [31:0] rec_handle,
    input logic [63:0] rec_frame,
    input logic [63:0] rec_mask0,
    input logic [63:0] rec_mask3
);

    logic done_rec;
    logic err_rec;
    logic done_clean;
    logic err_clean;

    // Record classes and the fields each class must leave clear.
    assign done_rec   = rec_valid && (rec_kind == cmd_pkg::KIND_DONE);
    assign err_rec    = rec_valid && (rec_kind == cmd_pkg::KIND_PARITY ||
                                      rec_kind == cmd_pkg::KIND_ZERO_FRAME);
    assign done_clean = (rec_handle == 32'd0) && (rec_mask0 == 64'd0) &&
                        (rec_frame[11:0] == 12'd0);
    assign err_clean  = (rec_frame == 64'd0) && (rec_mask3 == 64'd0);

    // A waiting record is not withdrawn.
    `ASSERT_CLK(a_rec_hold, clk, rst_n, rec_valid && !rec_ready |=> rec_valid)

    // End of measurement carries only the byte count, a multiple of 4096.
    `ASSERT_IMPLIES(a_done_clean, clk, rst_n, done_rec, done_clean)

    // Error records carry no frame number and no mask.
    `ASSERT_IMPLIES(a_err_clean, clk, rst_n, err_rec, err_clean)

    // A waiting record keeps its kind until it is taken.
    `ASSERT_CLK(a_rec_stable, clk, rst_n, rec_valid && !rec_ready |=> $stable(rec_kind))

endmodule

bind completion_message_decoder cmd_checker u_cmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec.valid),
    .rec_ready (rec.ready),
    .rec_kind  (rec.kind),
    .rec_handle(rec.handle),
    .rec_frame (rec.frame_or_bytes),
    .rec_mask0 (rec.mask_part0),
    .rec_mask3 (rec.mask_part3)
);
